// File: design/ptauv_pkg.sv
`timescale 1ns / 1ps
// ============================================================================
// ptauv_pkg
// Shared widths, constants and types of the angular U/V binning pipeline.
// ============================================================================
package ptauv_pkg;

    // Coordinates and configuration
    localparam int XW       = 24;          // point coordinate width
    localparam int ZW       = XW + 1;      // z plus reference
    localparam int UVW      = 18;          // uv_max width
    localparam int BCW      = 11;          // bin_count width
    localparam int CFG_DW   = 24;          // config data width
    localparam int CFG_AW   = 2;           // config index width
    localparam int MAX_BINS = 1024;
    localparam int BIN_W    = 10;          // bin index width

    localparam logic signed [XW-1:0]  Z_REF_RST     = '0;
    localparam logic [UVW-1:0]        UV_MAX_RST    = 18'd102944;
    localparam logic [BCW-1:0]        BIN_COUNT_RST = 11'd1024;

    // Radius: squares, sum and integer root of (x^2 + y^2) * 2^16
    localparam int SQW    = 2 * XW;        // one square
    localparam int R2W    = 2 * XW;        // sum of squares
    localparam int RSW    = 32;            // root width
    localparam int SQ_N   = RSW;           // one root bit per stage
    localparam int RAD_SH = 2 * RSW - R2W; // radicand scale (2^16)
    localparam int REMW   = RSW + 3;       // partial remainder

    // CORDIC
    localparam int ANGLE_ITERATIONS = 18;
    localparam int CW     = 58;            // rotated vector width
    localparam int AW     = 28;            // angle accumulator, 2^-24 rad
    localparam int PRE_SH = 22;            // operand prescale
    localparam int Z_SH   = 8;             // z scale to match root
    localparam int ACC_SH = 8;             // 2^-24 -> 2^-16 rad
    localparam logic signed [AW-1:0] ACC_RND      = 28'sd128;
    localparam logic signed [AW-1:0] HALF_PI_FINE = 28'sd26353589;

    localparam logic signed [AW-1:0] ATAN_FINE [24] = '{
        28'sd13176795, 28'sd7778716, 28'sd4110060, 28'sd2086331,
        28'sd1047214,  28'sd524117,  28'sd262123,  28'sd131069,
        28'sd65536,    28'sd32768,   28'sd16384,   28'sd8192,
        28'sd4096,     28'sd2048,    28'sd1024,    28'sd512,
        28'sd256,      28'sd128,     28'sd64,      28'sd32,
        28'sd16,       28'sd8,       28'sd4,       28'sd2
    };

    // Angle and split
    localparam int THETA_W   = 18;
    localparam int THETA_MAX = 205887;
    localparam int UW        = 19;         // U/V width
    localparam int PW        = THETA_W + XW;
    localparam int NUM_SH    = 9;          // times 512
    localparam int NUMW      = 52;         // dividend of the split
    localparam int DQ_N      = 19;         // quotient bits of the split
    localparam logic signed [UW-1:0] U_LIM = 19'sd205887;

    // Binning
    localparam int NW   = 20;              // c + uv_max
    localparam int BPW  = 30;              // (c + uv_max) * nb
    localparam int BQ_N = BCW;             // quotient bits of a bin

    // Pipeline depth
    localparam int NST = 3 + SQ_N + 1 + ANGLE_ITERATIONS + 4 + DQ_N + 4 + BQ_N + 1;

    typedef enum logic [CFG_AW-1:0] {
        CFG_Z_REF     = 2'd0,
        CFG_UV_MAX    = 2'd1,
        CFG_BIN_COUNT = 2'd2
    } t_cfg_idx;

endpackage

// File: design/ptauv_point_if.sv
`timescale 1ns / 1ps
// ============================================================================
// ptauv_point_if
// Point channel: one 3D point per word.
// ============================================================================
interface ptauv_point_if;
    logic                                valid;
    logic                                ready;
    logic signed [ptauv_pkg::XW-1:0]     point_x;
    logic signed [ptauv_pkg::XW-1:0]     point_y;
    logic signed [ptauv_pkg::XW-1:0]     point_z;

    modport source (output valid, output point_x, output point_y, output point_z,
                    input ready);
    modport sink   (input valid, input point_x, input point_y, input point_z,
                    output ready);
endinterface

// File: design/ptauv_result_if.sv
`timescale 1ns / 1ps
// ============================================================================
// ptauv_result_if
// Result channel: U/V coordinates, bins and range flag per word.
// ============================================================================
interface ptauv_result_if;
    logic                                valid;
    logic                                ready;
    logic signed [ptauv_pkg::UW-1:0]     u_coord;
    logic signed [ptauv_pkg::UW-1:0]     v_coord;
    logic [ptauv_pkg::BIN_W-1:0]         bin_u;
    logic [ptauv_pkg::BIN_W-1:0]         bin_v;
    logic                                in_range;

    modport source (output valid, output u_coord, output v_coord, output bin_u,
                    output bin_v, output in_range, input ready);
    modport sink   (input valid, input u_coord, input v_coord, input bin_u,
                    input bin_v, input in_range, output ready);
endinterface

// File: design/ptauv_cfg_if.sv
`timescale 1ns / 1ps
// ============================================================================
// ptauv_cfg_if
// Configuration write channel: register index and data per word.
// ============================================================================
interface ptauv_cfg_if;
    logic                                valid;
    logic                                ready;
    logic [ptauv_pkg::CFG_AW-1:0]        index;
    logic [ptauv_pkg::CFG_DW-1:0]        data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// File: design/point_to_angular_uv_bin_top.sv
`timescale 1ns / 1ps
// ============================================================================
// point_to_angular_uv_bin_top
// Polar angle of a point, split into U/V and binned, fully pipelined.
// ============================================================================
// Takes one point per cycle and returns one result word per point, in order.
// The depth of the pipe is set by the 32-stage root extraction of the radius,
// the 18 CORDIC stages for the angle, and the two restoring dividers (19 bits
// for the U/V split, 11 bits for the bins), each one bit per stage. The whole
// pipe advances when the output register is empty or taken, so a stall at the
// output holds every stage in place.
// Config writes are taken at any time but must only happen while idle.
module point_to_angular_uv_bin_top (
    input  logic            i_clk,
    input  logic            i_rst_n,
    ptauv_point_if.sink     i_pt,
    ptauv_result_if.source  o_res,
    ptauv_cfg_if.sink       i_cfg
);

    localparam int NI = ptauv_pkg::ANGLE_ITERATIONS;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic signed [ptauv_pkg::XW-1:0]  r_z_ref;
    logic [ptauv_pkg::UVW-1:0]        r_uv_max;
    logic [ptauv_pkg::BCW-1:0]        r_bin_count;
    logic [ptauv_pkg::BCW-1:0]        nb;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_z_ref     <= ptauv_pkg::Z_REF_RST;
            r_uv_max    <= ptauv_pkg::UV_MAX_RST;
            r_bin_count <= ptauv_pkg::BIN_COUNT_RST;
        end else if (i_cfg.valid) begin
            unique case (ptauv_pkg::t_cfg_idx'(i_cfg.index))
                ptauv_pkg::CFG_Z_REF:     r_z_ref     <= i_cfg.data[ptauv_pkg::XW-1:0];
                ptauv_pkg::CFG_UV_MAX:    r_uv_max    <= i_cfg.data[ptauv_pkg::UVW-1:0];
                ptauv_pkg::CFG_BIN_COUNT: r_bin_count <= i_cfg.data[ptauv_pkg::BCW-1:0];
                default: ;
            endcase
        end
    end

    // effective bin count
    assign nb = (r_bin_count > ptauv_pkg::BCW'(ptauv_pkg::MAX_BINS))
              ? ptauv_pkg::BCW'(ptauv_pkg::MAX_BINS) : r_bin_count;

    // ------------------------------------------------------------------
    // Pipeline advance and valid chain
    // ------------------------------------------------------------------
    logic                      adv;
    logic [ptauv_pkg::NST-1:0] r_vld;

    assign adv        = !r_vld[ptauv_pkg::NST-1] || o_res.ready;
    assign i_pt.ready = adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (adv) begin
            r_vld <= {r_vld[ptauv_pkg::NST-2:0], i_pt.valid};
        end
    end

    // ------------------------------------------------------------------
    // Stages 1-3: z offset, squares, sum of squares
    // ------------------------------------------------------------------
    logic signed [ptauv_pkg::XW-1:0]  r_s1_x, r_s1_y, r_s2_x, r_s2_y, r_s3_x, r_s3_y;
    logic signed [ptauv_pkg::ZW-1:0]  r_s1_zv, r_s2_zv, r_s3_zv;
    logic [ptauv_pkg::XW-1:0]         ax1, ay1;
    logic [ptauv_pkg::SQW-1:0]        r_s2_xx, r_s2_yy;
    logic [ptauv_pkg::R2W-1:0]        r_s3_r2;

    assign ax1 = r_s1_x[ptauv_pkg::XW-1] ? ptauv_pkg::XW'(-r_s1_x) : ptauv_pkg::XW'(r_s1_x);
    assign ay1 = r_s1_y[ptauv_pkg::XW-1] ? ptauv_pkg::XW'(-r_s1_y) : ptauv_pkg::XW'(r_s1_y);

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_s1_x  <= i_pt.point_x;
            r_s1_y  <= i_pt.point_y;
            r_s1_zv <= ptauv_pkg::ZW'(i_pt.point_z) + ptauv_pkg::ZW'(r_z_ref);
            r_s2_x  <= r_s1_x;
            r_s2_y  <= r_s1_y;
            r_s2_zv <= r_s1_zv;
            r_s2_xx <= ptauv_pkg::SQW'(ax1) * ptauv_pkg::SQW'(ax1);
            r_s2_yy <= ptauv_pkg::SQW'(ay1) * ptauv_pkg::SQW'(ay1);
            r_s3_x  <= r_s2_x;
            r_s3_y  <= r_s2_y;
            r_s3_zv <= r_s2_zv;
            r_s3_r2 <= ptauv_pkg::R2W'(r_s2_xx) + ptauv_pkg::R2W'(r_s2_yy);
        end
    end

    // ------------------------------------------------------------------
    // Root extraction: floor(256 * r), one bit per stage
    // ------------------------------------------------------------------
    logic [ptauv_pkg::REMW-1:0]       r_sq_rem  [ptauv_pkg::SQ_N];
    logic [ptauv_pkg::RSW-1:0]        r_sq_root [ptauv_pkg::SQ_N];
    logic [ptauv_pkg::R2W-1:0]        r_sq_r2   [ptauv_pkg::SQ_N];
    logic signed [ptauv_pkg::XW-1:0]  r_sq_x    [ptauv_pkg::SQ_N];
    logic signed [ptauv_pkg::XW-1:0]  r_sq_y    [ptauv_pkg::SQ_N];
    logic signed [ptauv_pkg::ZW-1:0]  r_sq_zv   [ptauv_pkg::SQ_N];

    for (genvar j = 0; j < ptauv_pkg::SQ_N; j++) begin : g_sq
        logic [ptauv_pkg::REMW-1:0]      rem_i, rem_s, trial;
        logic [ptauv_pkg::RSW-1:0]       root_i;
        logic [ptauv_pkg::R2W-1:0]       r2_i;
        logic signed [ptauv_pkg::XW-1:0] x_i, y_i;
        logic signed [ptauv_pkg::ZW-1:0] zv_i;
        logic [2*ptauv_pkg::RSW-1:0]     rad;

        if (j == 0) begin : g_first
            assign rem_i  = '0;
            assign root_i = '0;
            assign r2_i   = r_s3_r2;
            assign x_i    = r_s3_x;
            assign y_i    = r_s3_y;
            assign zv_i   = r_s3_zv;
        end else begin : g_next
            assign rem_i  = r_sq_rem[j-1];
            assign root_i = r_sq_root[j-1];
            assign r2_i   = r_sq_r2[j-1];
            assign x_i    = r_sq_x[j-1];
            assign y_i    = r_sq_y[j-1];
            assign zv_i   = r_sq_zv[j-1];
        end

        assign rad   = {r2_i, {ptauv_pkg::RAD_SH{1'b0}}};
        assign rem_s = {rem_i[ptauv_pkg::REMW-3:0], rad[2*(ptauv_pkg::SQ_N-1-j) +: 2]};
        assign trial = ptauv_pkg::REMW'({root_i, 2'b01});

        always_ff @(posedge i_clk) begin
            if (adv) begin
                if (rem_s >= trial) begin
                    r_sq_rem[j]  <= rem_s - trial;
                    r_sq_root[j] <= {root_i[ptauv_pkg::RSW-2:0], 1'b1};
                end else begin
                    r_sq_rem[j]  <= rem_s;
                    r_sq_root[j] <= {root_i[ptauv_pkg::RSW-2:0], 1'b0};
                end
                r_sq_r2[j] <= r2_i;
                r_sq_x[j]  <= x_i;
                r_sq_y[j]  <= y_i;
                r_sq_zv[j] <= zv_i;
            end
        end
    end

    // ------------------------------------------------------------------
    // CORDIC: load stage, then one micro-rotation per stage
    // ------------------------------------------------------------------
    logic signed [ptauv_pkg::CW-1:0]  r_cd_cx  [NI+1];
    logic signed [ptauv_pkg::CW-1:0]  r_cd_cy  [NI+1];
    logic signed [ptauv_pkg::AW-1:0]  r_cd_acc [NI+1];
    logic [ptauv_pkg::RSW-1:0]        r_cd_rs  [NI+1];
    logic signed [ptauv_pkg::XW-1:0]  r_cd_x   [NI+1];
    logic signed [ptauv_pkg::XW-1:0]  r_cd_y   [NI+1];
    logic [ptauv_pkg::ZW:0]           zmag;
    logic [ptauv_pkg::RSW-1:0]        rs_sq;
    logic signed [ptauv_pkg::ZW-1:0]  zv_sq;

    assign rs_sq = r_sq_root[ptauv_pkg::SQ_N-1];
    assign zv_sq = r_sq_zv[ptauv_pkg::SQ_N-1];
    assign zmag  = zv_sq[ptauv_pkg::ZW-1] ? (ptauv_pkg::ZW+1)'(-zv_sq)
                                          : (ptauv_pkg::ZW+1)'(zv_sq);

    // negative z term is pre-rotated by pi/2
    always_ff @(posedge i_clk) begin
        if (adv) begin
            if (zv_sq[ptauv_pkg::ZW-1]) begin
                r_cd_cx[0]  <= ptauv_pkg::CW'({rs_sq, {ptauv_pkg::PRE_SH{1'b0}}});
                r_cd_cy[0]  <= ptauv_pkg::CW'({zmag,
                                 {(ptauv_pkg::PRE_SH + ptauv_pkg::Z_SH){1'b0}}});
                r_cd_acc[0] <= ptauv_pkg::HALF_PI_FINE;
            end else begin
                r_cd_cx[0]  <= ptauv_pkg::CW'({zmag,
                                 {(ptauv_pkg::PRE_SH + ptauv_pkg::Z_SH){1'b0}}});
                r_cd_cy[0]  <= ptauv_pkg::CW'({rs_sq, {ptauv_pkg::PRE_SH{1'b0}}});
                r_cd_acc[0] <= '0;
            end
            r_cd_rs[0] <= rs_sq;
            r_cd_x[0]  <= r_sq_x[ptauv_pkg::SQ_N-1];
            r_cd_y[0]  <= r_sq_y[ptauv_pkg::SQ_N-1];
        end
    end

    for (genvar k = 0; k < NI; k++) begin : g_cd
        logic signed [ptauv_pkg::CW-1:0] dx, dy;

        assign dx = r_cd_cy[k] >>> k;
        assign dy = r_cd_cx[k] >>> k;

        always_ff @(posedge i_clk) begin
            if (adv) begin
                if (!r_cd_cy[k][ptauv_pkg::CW-1]) begin
                    r_cd_cx[k+1]  <= r_cd_cx[k] + dx;
                    r_cd_cy[k+1]  <= r_cd_cy[k] - dy;
                    r_cd_acc[k+1] <= r_cd_acc[k] + ptauv_pkg::ATAN_FINE[k];
                end else begin
                    r_cd_cx[k+1]  <= r_cd_cx[k] - dx;
                    r_cd_cy[k+1]  <= r_cd_cy[k] + dy;
                    r_cd_acc[k+1] <= r_cd_acc[k] - ptauv_pkg::ATAN_FINE[k];
                end
                r_cd_rs[k+1] <= r_cd_rs[k];
                r_cd_x[k+1]  <= r_cd_x[k];
                r_cd_y[k+1]  <= r_cd_y[k];
            end
        end
    end

    // ------------------------------------------------------------------
    // Angle rounding to 2^-16 rad and clamp
    // ------------------------------------------------------------------
    logic signed [ptauv_pkg::AW-1:0]  acc_rnd, acc_sh;
    logic [ptauv_pkg::THETA_W-1:0]    r_th_theta;
    logic [ptauv_pkg::RSW-1:0]        r_th_rs;
    logic signed [ptauv_pkg::XW-1:0]  r_th_c [2];

    assign acc_rnd = r_cd_acc[NI] + ptauv_pkg::ACC_RND;
    assign acc_sh  = acc_rnd >>> ptauv_pkg::ACC_SH;

    always_ff @(posedge i_clk) begin
        if (adv) begin
            if (acc_sh[ptauv_pkg::AW-1]) begin
                r_th_theta <= '0;
            end else if (acc_sh[ptauv_pkg::AW-2:0] > (ptauv_pkg::AW-1)'(ptauv_pkg::THETA_MAX)) begin
                r_th_theta <= ptauv_pkg::THETA_W'(ptauv_pkg::THETA_MAX);
            end else begin
                r_th_theta <= acc_sh[ptauv_pkg::THETA_W-1:0];
            end
            r_th_rs   <= r_cd_rs[NI];
            r_th_c[0] <= r_cd_x[NI];
            r_th_c[1] <= r_cd_y[NI];
        end
    end

    // ------------------------------------------------------------------
    // Split: theta * |c| and dividend (lane 0 = U, 1 = V)
    // ------------------------------------------------------------------
    logic [ptauv_pkg::XW-1:0]         cmag [2];
    logic [ptauv_pkg::PW-1:0]         r_mu_p [2];
    logic                             r_mu_neg [2];
    logic [ptauv_pkg::THETA_W-1:0]    r_mu_theta, r_nm_theta;
    logic [ptauv_pkg::RSW-1:0]        r_mu_rs, r_nm_rs;
    logic [ptauv_pkg::NUMW-1:0]       r_nm_num [2];
    logic                             r_nm_neg [2];

    always_comb begin
        for (int l = 0; l < 2; l++) begin
            cmag[l] = r_th_c[l][ptauv_pkg::XW-1] ? ptauv_pkg::XW'(-r_th_c[l])
                                                 : ptauv_pkg::XW'(r_th_c[l]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            for (int l = 0; l < 2; l++) begin
                r_mu_p[l]   <= ptauv_pkg::PW'(r_th_theta) * ptauv_pkg::PW'(cmag[l]);
                r_mu_neg[l] <= r_th_c[l][ptauv_pkg::XW-1];
                r_nm_num[l] <= ptauv_pkg::NUMW'({r_mu_p[l], {ptauv_pkg::NUM_SH{1'b0}}})
                             + ptauv_pkg::NUMW'(r_mu_rs);
                r_nm_neg[l] <= r_mu_neg[l];
            end
            r_mu_theta <= r_th_theta;
            r_mu_rs    <= r_th_rs;
            r_nm_theta <= r_mu_theta;
            r_nm_rs    <= r_mu_rs;
        end
    end

    // restoring divider by 2*rs; stage 0 flags a quotient past 19 bits
    logic [ptauv_pkg::NUMW-1:0]       r_dv_rem [ptauv_pkg::DQ_N+1][2];
    logic [ptauv_pkg::DQ_N-1:0]       r_dv_q   [ptauv_pkg::DQ_N+1][2];
    logic                             r_dv_ovf [ptauv_pkg::DQ_N+1][2];
    logic                             r_dv_neg [ptauv_pkg::DQ_N+1][2];
    logic [ptauv_pkg::THETA_W-1:0]    r_dv_theta [ptauv_pkg::DQ_N+1];
    logic [ptauv_pkg::RSW-1:0]        r_dv_rs    [ptauv_pkg::DQ_N+1];

    always_ff @(posedge i_clk) begin
        if (adv) begin
            for (int l = 0; l < 2; l++) begin
                r_dv_rem[0][l] <= r_nm_num[l];
                r_dv_q[0][l]   <= '0;
                r_dv_ovf[0][l] <= r_nm_num[l] >=
                    (ptauv_pkg::NUMW'({r_nm_rs, 1'b0}) << ptauv_pkg::DQ_N);
                r_dv_neg[0][l] <= r_nm_neg[l];
            end
            r_dv_theta[0] <= r_nm_theta;
            r_dv_rs[0]    <= r_nm_rs;
        end
    end

    for (genvar j = 1; j <= ptauv_pkg::DQ_N; j++) begin : g_dv
        logic [ptauv_pkg::NUMW-1:0] dsh;

        assign dsh = ptauv_pkg::NUMW'({r_dv_rs[j-1], 1'b0}) << (ptauv_pkg::DQ_N - j);

        always_ff @(posedge i_clk) begin
            if (adv) begin
                for (int l = 0; l < 2; l++) begin
                    if (r_dv_rem[j-1][l] >= dsh) begin
                        r_dv_rem[j][l] <= r_dv_rem[j-1][l] - dsh;
                        r_dv_q[j][l]   <= r_dv_q[j-1][l]
                                        | (ptauv_pkg::DQ_N'(1) << (ptauv_pkg::DQ_N - j));
                    end else begin
                        r_dv_rem[j][l] <= r_dv_rem[j-1][l];
                        r_dv_q[j][l]   <= r_dv_q[j-1][l];
                    end
                    r_dv_ovf[j][l] <= r_dv_ovf[j-1][l];
                    r_dv_neg[j][l] <= r_dv_neg[j-1][l];
                end
                r_dv_theta[j] <= r_dv_theta[j-1];
                r_dv_rs[j]    <= r_dv_rs[j-1];
            end
        end
    end

    // clamp to theta, apply sign; on-axis point gives zero
    logic [ptauv_pkg::DQ_N-1:0]       qc [2];
    logic signed [ptauv_pkg::UW-1:0]  r_sp_c [2];

    always_comb begin
        for (int l = 0; l < 2; l++) begin
            if (r_dv_rs[ptauv_pkg::DQ_N] == '0) begin
                qc[l] = '0;
            end else if (r_dv_ovf[ptauv_pkg::DQ_N][l] ||
                         r_dv_q[ptauv_pkg::DQ_N][l] >
                         ptauv_pkg::DQ_N'(r_dv_theta[ptauv_pkg::DQ_N])) begin
                qc[l] = ptauv_pkg::DQ_N'(r_dv_theta[ptauv_pkg::DQ_N]);
            end else begin
                qc[l] = r_dv_q[ptauv_pkg::DQ_N][l];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            for (int l = 0; l < 2; l++) begin
                r_sp_c[l] <= r_dv_neg[ptauv_pkg::DQ_N][l]
                           ? ptauv_pkg::UW'(-$signed({1'b0, qc[l]}))
                           : ptauv_pkg::UW'($signed({1'b0, qc[l]}));
            end
        end
    end

    // ------------------------------------------------------------------
    // Binning: (c + uv_max) * nb / (2 * uv_max)
    // ------------------------------------------------------------------
    logic signed [ptauv_pkg::NW-1:0]  nsum [2];
    logic signed [ptauv_pkg::NW-1:0]  r_ba_n [2];
    logic                             r_ba_bad [2], r_bm_bad [2];
    logic signed [ptauv_pkg::UW-1:0]  r_ba_c [2], r_bm_c [2];
    logic [ptauv_pkg::BPW-1:0]        r_bm_p [2];

    always_comb begin
        for (int l = 0; l < 2; l++) begin
            nsum[l] = ptauv_pkg::NW'(r_sp_c[l])
                    + ptauv_pkg::NW'($signed({1'b0, r_uv_max}));
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            for (int l = 0; l < 2; l++) begin
                r_ba_n[l]   <= nsum[l];
                r_ba_bad[l] <= (r_uv_max == '0) || (nb == '0) || nsum[l][ptauv_pkg::NW-1];
                r_ba_c[l]   <= r_sp_c[l];
                r_bm_p[l]   <= ptauv_pkg::BPW'(r_ba_n[l][ptauv_pkg::NW-2:0])
                             * ptauv_pkg::BPW'(nb);
                r_bm_bad[l] <= r_ba_bad[l];
                r_bm_c[l]   <= r_ba_c[l];
            end
        end
    end

    // restoring divider by 2*uv_max; stage 0 flags a quotient past 11 bits
    logic [ptauv_pkg::BPW-1:0]        r_bd_rem [ptauv_pkg::BQ_N+1][2];
    logic [ptauv_pkg::BQ_N-1:0]       r_bd_q   [ptauv_pkg::BQ_N+1][2];
    logic                             r_bd_ovf [ptauv_pkg::BQ_N+1][2];
    logic                             r_bd_bad [ptauv_pkg::BQ_N+1][2];
    logic signed [ptauv_pkg::UW-1:0]  r_bd_c   [ptauv_pkg::BQ_N+1][2];

    always_ff @(posedge i_clk) begin
        if (adv) begin
            for (int l = 0; l < 2; l++) begin
                r_bd_rem[0][l] <= r_bm_p[l];
                r_bd_q[0][l]   <= '0;
                r_bd_ovf[0][l] <= r_bm_p[l] >=
                    (ptauv_pkg::BPW'({r_uv_max, 1'b0}) << ptauv_pkg::BQ_N);
                r_bd_bad[0][l] <= r_bm_bad[l];
                r_bd_c[0][l]   <= r_bm_c[l];
            end
        end
    end

    for (genvar j = 1; j <= ptauv_pkg::BQ_N; j++) begin : g_bd
        logic [ptauv_pkg::BPW-1:0] dsh;

        assign dsh = ptauv_pkg::BPW'({r_uv_max, 1'b0}) << (ptauv_pkg::BQ_N - j);

        always_ff @(posedge i_clk) begin
            if (adv) begin
                for (int l = 0; l < 2; l++) begin
                    if (r_bd_rem[j-1][l] >= dsh) begin
                        r_bd_rem[j][l] <= r_bd_rem[j-1][l] - dsh;
                        r_bd_q[j][l]   <= r_bd_q[j-1][l]
                                        | (ptauv_pkg::BQ_N'(1) << (ptauv_pkg::BQ_N - j));
                    end else begin
                        r_bd_rem[j][l] <= r_bd_rem[j-1][l];
                        r_bd_q[j][l]   <= r_bd_q[j-1][l];
                    end
                    r_bd_ovf[j][l] <= r_bd_ovf[j-1][l];
                    r_bd_bad[j][l] <= r_bd_bad[j-1][l];
                    r_bd_c[j][l]   <= r_bd_c[j-1][l];
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Output register
    // ------------------------------------------------------------------
    logic                             ok [2];
    logic                             all_ok;
    logic signed [ptauv_pkg::UW-1:0]  r_out_u, r_out_v;
    logic [ptauv_pkg::BIN_W-1:0]      r_out_bu, r_out_bv;
    logic                             r_out_ok;

    always_comb begin
        for (int l = 0; l < 2; l++) begin
            ok[l] = !r_bd_bad[ptauv_pkg::BQ_N][l] && !r_bd_ovf[ptauv_pkg::BQ_N][l]
                 && (r_bd_q[ptauv_pkg::BQ_N][l] < nb);
        end
    end
    assign all_ok = ok[0] && ok[1];

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_out_u  <= r_bd_c[ptauv_pkg::BQ_N][0];
            r_out_v  <= r_bd_c[ptauv_pkg::BQ_N][1];
            r_out_bu <= all_ok ? r_bd_q[ptauv_pkg::BQ_N][0][ptauv_pkg::BIN_W-1:0] : '0;
            r_out_bv <= all_ok ? r_bd_q[ptauv_pkg::BQ_N][1][ptauv_pkg::BIN_W-1:0] : '0;
            r_out_ok <= all_ok;
        end
    end

    assign o_res.valid    = r_vld[ptauv_pkg::NST-1];
    assign o_res.u_coord  = r_out_u;
    assign o_res.v_coord  = r_out_v;
    assign o_res.bin_u    = r_out_bu;
    assign o_res.bin_v    = r_out_bv;
    assign o_res.in_range = r_out_ok;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_bins_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && !o_res.in_range) |-> (o_res.bin_u == '0 && o_res.bin_v == '0))
        else $error("bins not cleared on out-of-range word");

    a_bin_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && o_res.in_range) |->
        (ptauv_pkg::BCW'(o_res.bin_u) < nb && ptauv_pkg::BCW'(o_res.bin_v) < nb))
        else $error("in-range bin at or past bin count");

    a_uv_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid |->
        (o_res.u_coord <= ptauv_pkg::U_LIM && o_res.u_coord >= -ptauv_pkg::U_LIM &&
         o_res.v_coord <= ptauv_pkg::U_LIM && o_res.v_coord >= -ptauv_pkg::U_LIM))
        else $error("U/V beyond angle limit");

endmodule
